// File: rtl/core/frustum_box_cull_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the box culling block
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_ASSERT_SVH
`define FRUSTUM_BOX_CULL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FBC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbc assertion failed");

`endif

// File: rtl/core/fbc_pkg.sv
// ---------------------------------------------------------------------------
// fbc_pkg
// Constants, register indexes and helpers for the frustum box culler.
// ---------------------------------------------------------------------------
package fbc_pkg;

	localparam int PLANE_COUNT   = 6;
	localparam int PLANE_REGS    = 6;
	localparam int PLANES_TESTED = (PLANE_COUNT < PLANE_REGS) ? PLANE_COUNT : PLANE_REGS;

	localparam int COORD_W   = 16;
	localparam int COEF_W    = 16;
	localparam int PLANE_W   = 64;
	localparam int Q_SHIFT   = 14;
	localparam int PROD_W    = COORD_W + COEF_W;
	localparam int SUM_W     = PROD_W + 3;
	localparam int IDX_W     = 3;
	localparam int IN_DATA_W = 6 * COORD_W;
	localparam int OUT_DATA_W = 8;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	// Register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_NEAR   = 3'd0;
	localparam logic [IDX_W-1:0] REG_FAR    = 3'd1;
	localparam logic [IDX_W-1:0] REG_LEFT   = 3'd2;
	localparam logic [IDX_W-1:0] REG_RIGHT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_BOTTOM = 3'd4;
	localparam logic [IDX_W-1:0] REG_TOP    = 3'd5;

	// Corner coordinate that maximizes coef*coord: the larger bound for a
	// non-negative coefficient, the smaller one otherwise.
	function automatic coord_t pick_bound(coef_t coef, coord_t b0, coord_t b1);
		logic b0_gt;
		b0_gt = (b0 > b1);
		if (coef[COEF_W-1])
			return b0_gt ? b1 : b0;
		else
			return b0_gt ? b0 : b1;
	endfunction

	function automatic sum_t ext_prod(prod_t p);
		return sum_t'({{(SUM_W-PROD_W){p[PROD_W-1]}}, p});
	endfunction

	// d is a whole number; align it to Q.14
	function automatic sum_t align_d(coef_t d);
		return sum_t'({{(SUM_W-COEF_W-Q_SHIFT){d[COEF_W-1]}}, d, {Q_SHIFT{1'b0}}});
	endfunction

endpackage

// File: rtl/core/frustum_box_cull.sv
// ---------------------------------------------------------------------------
// frustum_box_cull
// Tests an axis-aligned box against six clipping planes, one box per beat.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one box per beat as six
//   signed 16-bit bounds. Master stream (m_tvalid/m_tready/m_tdata) returns
//   one beat per box, in order, with is_outside in bit 0.
//   Planes are loaded through cfg_we/cfg_index/cfg_data while no box is in
//   flight; indexes 0..5 are near, far, left, right, bottom, top, others
//   are dropped. Each plane packs a, b, c (Q2.14) and d (whole number).
//   Per plane, each axis bound is chosen by coefficient sign so that one
//   multiply per axis yields the largest corner value; the box is outside
//   when that maximum is negative for any plane.
//   Accepted boxes pass through the product register, then the result register, which drives m_tvalid.
//   Throughput: one box per cycle while m_tready is high; 18 16x16 multipliers run in parallel.
//   A stalled receiver holds the result register; the upper stages keep
//   taking beats until every stage is full, then s_tready drops.
//   Reset clears all stage valid bits and zeroes the planes, which never cull.
// ---------------------------------------------------------------------------
`include "frustum_box_cull_assert.svh"

module frustum_box_cull (
	input  logic                           clk,
	input  logic                           arst_n,
	// cfg
	input  logic                           cfg_we,
	input  logic [fbc_pkg::IDX_W-1:0]      cfg_index,
	input  logic [fbc_pkg::PLANE_W-1:0]    cfg_data,
	// slave stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// box_x_min, box_x_max, box_y_min, box_y_max, box_z_min, box_z_max
	input  logic [fbc_pkg::IN_DATA_W-1:0]  s_tdata,
	// master stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// is_outside, then seven zero bits
	output logic [fbc_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int NP = fbc_pkg::PLANES_TESTED;

	logic [fbc_pkg::PLANE_W-1:0] plane_q [fbc_pkg::PLANE_REGS];

	fbc_pkg::coord_t box_s1 [6];
	logic            v_s1;
	fbc_pkg::prod_t  prod_s2 [NP][3];
	fbc_pkg::coef_t  d_s2 [NP];
	logic            v_s2;
	logic            outside_s3;
	logic            v_s3;

	logic ready_s1, ready_s2, ready_s3;
	logic [NP-1:0] neg_plane;

	assign ready_s3 = !v_s3 || m_tready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign s_tready = ready_s1;

	// plane registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fbc_pkg::PLANE_REGS; i++)
				plane_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fbc_pkg::REG_NEAR:   plane_q[0] <= cfg_data;
				fbc_pkg::REG_FAR:    plane_q[1] <= cfg_data;
				fbc_pkg::REG_LEFT:   plane_q[2] <= cfg_data;
				fbc_pkg::REG_RIGHT:  plane_q[3] <= cfg_data;
				fbc_pkg::REG_BOTTOM: plane_q[4] <= cfg_data;
				fbc_pkg::REG_TOP:    plane_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			for (int i = 0; i < 6; i++)
				box_s1[i] <= s_tdata[i*fbc_pkg::COORD_W +: fbc_pkg::COORD_W];
		end
	end

	// stage 2: pick the worst-case corner per axis and multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	for (genvar p = 0; p < NP; p++) begin : g_plane
		fbc_pkg::coef_t  coef [3];
		fbc_pkg::coord_t sel  [3];
		fbc_pkg::sum_t   total;

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				coef[k] = plane_q[p][k*fbc_pkg::COEF_W +: fbc_pkg::COEF_W];
				sel[k]  = fbc_pkg::pick_bound(coef[k], box_s1[2*k], box_s1[2*k+1]);
			end
		end

		always_ff @(posedge clk) begin
			if (ready_s2 && v_s1) begin
				for (int k = 0; k < 3; k++)
					prod_s2[p][k] <= coef[k] * sel[k];
				d_s2[p] <= plane_q[p][3*fbc_pkg::COEF_W +: fbc_pkg::COEF_W];
			end
		end

		// the largest corner value is negative: every corner is outside
		assign total = fbc_pkg::ext_prod(prod_s2[p][0]) + fbc_pkg::ext_prod(prod_s2[p][1])
			+ fbc_pkg::ext_prod(prod_s2[p][2]) + fbc_pkg::align_d(d_s2[p]);
		assign neg_plane[p] = total[fbc_pkg::SUM_W-1];
	end

	// stage 3: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			outside_s3 <= |neg_plane;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {{(fbc_pkg::OUT_DATA_W-1){1'b0}}, outside_s3};

	`FBC_ASSERT_SAME(a_full_blocks_input, v_s1 && v_s2 && v_s3 && !m_tready, !s_tready)
	`FBC_ASSERT_NEXT(a_s2_reaches_output, v_s2 && ready_s3, m_tvalid)
	`FBC_ASSERT_NEXT(a_s1_reaches_s2, v_s1 && ready_s2, v_s2)
	`FBC_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[fbc_pkg::OUT_DATA_W-1:1] == '0)

endmodule

// File: tb/sv/tb_frustum_box_cull.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_frustum_box_cull
// Streams boxes through the culler under several plane sets and checks
// every is_outside beat against a tabled value or a corner-by-corner
// evaluation of the loaded planes, with random gaps on both streams and
// one long receiver stall.
// ---------------------------------------------------------------------------
module tb_frustum_box_cull;

	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 116;
	localparam int HOLD_CYCLES = 48;
	localparam int STALL_LIMIT = 1000;
	localparam int RST_ROWS    = 3;
	localparam int DIR_ROWS    = 21;
	localparam int MAX_PRINTS  = 40;

	// plane sets
	localparam int PK_DIRECTED = 0;
	localparam int PK_MAX      = 1;
	localparam int PK_MIN      = 2;
	localparam int PK_RANDOM   = 3;

	// x_min lands in the low bits of s_tdata
	typedef struct packed {
		fbc_pkg::coord_t z_max, z_min, y_max, y_min, x_max, x_min;
	} box_t;

	typedef struct packed {
		fbc_pkg::coord_t x0, x1, y0, y1, z0, z1;
		logic   typed;
		logic   outside;
	} dir_row_t;

	// First RST_ROWS rows run with the reset planes, the rest with PK_DIRECTED:
	// x >= 0, z <= 100, x <= 16383, y >= -32767, one zero plane, one always-in.
	localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
		'{-32768, 32767, -32768, 32767, -32768, 32767, 1'b1, 1'b0},
		'{0, 0, 0, 0, 0, 0, 1'b1, 1'b0},
		'{-32768, -32768, -32768, -32768, -32768, -32768, 1'b1, 1'b0},
		'{1, 10, 0, 0, 0, 0, 1'b1, 1'b0},
		'{-10, -1, 0, 0, 0, 0, 1'b1, 1'b1},
		'{-1, -10, 0, 0, 0, 0, 1'b1, 1'b1},
		'{-10, 0, 0, 0, 0, 0, 1'b1, 1'b0},
		'{0, 5, 0, 0, 101, 200, 1'b1, 1'b1},
		'{0, 5, 0, 0, 200, 101, 1'b1, 1'b1},
		'{0, 5, 0, 0, 100, 100, 1'b1, 1'b0},
		'{16384, 32767, 0, 0, 0, 0, 1'b1, 1'b1},
		'{16383, 32767, 0, 0, 0, 0, 1'b1, 1'b0},
		'{0, 0, -32768, -32768, 0, 0, 1'b1, 1'b1},
		'{0, 0, -32767, -32767, 0, 0, 1'b1, 1'b0},
		'{0, 0, -32767, -32768, 0, 0, 1'b1, 1'b0},
		'{-32768, 32767, -32768, 32767, -32768, 32767, 1'b1, 1'b0},
		'{-32768, -32768, 0, 0, 0, 0, 1'b1, 1'b1},
		'{32767, 32767, 32767, 32767, -32768, -32768, 1'b1, 1'b1},
		'{123, -456, 789, -1011, 1213, -1415, 1'b0, 1'b0},
		'{5000, -7, 32767, -32768, 99, -100, 1'b0, 1'b0},
		'{-1, -1, -1, -1, -1, -1, 1'b0, 1'b0}
	};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [fbc_pkg::IDX_W-1:0]      cfg_index;
	logic [fbc_pkg::PLANE_W-1:0]    cfg_data;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [fbc_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [fbc_pkg::OUT_DATA_W-1:0] m_tdata;

	logic [fbc_pkg::PLANE_W-1:0] plane_q [fbc_pkg::PLANE_REGS];
	bit                 outside_q [$];
	bit                 want_outside;
	int                 mismatch_cnt = 0;
	int                 quiet_cycles = 0;
	bit                 idle_on;
	bit                 hold_req;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	frustum_box_cull u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Outside when some plane puts all eight corners below zero.
	function automatic bit box_culled(box_t b);
		longint xs [2];
		longint ys [2];
		longint zs [2];
		longint ca, cb, cc, cd, acc;
		int     n_in;
		xs[0] = b.x_min;
		xs[1] = b.x_max;
		ys[0] = b.y_min;
		ys[1] = b.y_max;
		zs[0] = b.z_min;
		zs[1] = b.z_max;
		for (int p = 0; p < fbc_pkg::PLANES_TESTED; p++) begin
			ca = $signed(plane_q[p][15:0]);
			cb = $signed(plane_q[p][31:16]);
			cc = $signed(plane_q[p][47:32]);
			cd = $signed(plane_q[p][63:48]);
			cd = cd <<< fbc_pkg::Q_SHIFT;
			n_in = 0;
			for (int i = 0; i < 2; i++)
				for (int j = 0; j < 2; j++)
					for (int k = 0; k < 2; k++) begin
						acc = ca * xs[i] + cb * ys[j] + cc * zs[k] + cd;
						if (acc >= 0)
							n_in++;
					end
			if (n_in == 0)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic fbc_pkg::coord_t rand_coord(int spread, fbc_pkg::coord_t centre);
		if ($urandom_range(0, 15) == 0) begin
			case ($urandom_range(0, 3))
				0: return 16'h8000;
				1: return 16'h7FFF;
				2: return 16'h0000;
				default: return 16'hFFFF;
			endcase
		end
		if (spread == 0)
			return fbc_pkg::coord_t'($urandom);
		return fbc_pkg::coord_t'(int'(centre) + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_PRINTS)
			$display("%0t ERROR %s", $time, msg);
	endtask

	// Write all eight indexes; the two past REG_TOP must be dropped.
	task automatic load_planes(input int kind);
		logic [fbc_pkg::PLANE_W-1:0] val;
		for (int r = 0; r < 8; r++) begin
			case (kind)
				PK_DIRECTED: begin
					case (r)
						fbc_pkg::REG_NEAR:
							val = {16'h0000, 16'h0000, 16'h0000, 16'h4000};
						fbc_pkg::REG_FAR:
							val = {16'd100, 16'hC000, 16'h0000, 16'h0000};
						fbc_pkg::REG_LEFT:
							val = '0;
						fbc_pkg::REG_RIGHT:
							val = {16'h7FFF, 16'h0000, 16'h0000, 16'h8000};
						fbc_pkg::REG_BOTTOM:
							val = {16'h7FFF, 16'h0000, 16'h4000, 16'h0000};
						default:
							val = {16'h7FFF, 16'h0000, 16'hC000, 16'h0000};
					endcase
				end
				PK_MAX: val = {4{16'h7FFF}};
				PK_MIN: val = {4{16'h8000}};
				default: begin
					if ($urandom_range(0, 5) == 0)
						val = '0;
					else begin
						val = {$urandom, $urandom};
						// small offsets keep near-origin boxes on both sides
						if ($urandom_range(0, 1) == 1)
							val[63:48] = fbc_pkg::coef_t'(
								int'($urandom_range(0, 6000)) - 3000);
					end
				end
			endcase
			if (r > fbc_pkg::REG_TOP)
				val = {$urandom, $urandom};
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= r[fbc_pkg::IDX_W-1:0];
			cfg_data  <= val;
			if (r <= fbc_pkg::REG_TOP)
				plane_q[r] = val;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_box(input box_t b, input bit typed, input bit typed_outside);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		outside_q.push_back(typed ? typed_outside : box_culled(b));
	endtask

	// Drop valid and hold until every pending result has come back.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outside_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!idle_on)
				m_tready <= 1'b1;
			else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (outside_q.size() == 0)
				report_mismatch("result beat with no box pending");
			else begin
				want_outside = outside_q.pop_front();
				if (m_tdata[0] !== want_outside)
					report_mismatch($sformatf("is_outside %b, want %b", m_tdata[0],
						want_outside));
				if (m_tdata[fbc_pkg::OUT_DATA_W-1:1] !== '0)
					report_mismatch($sformatf("pad bits %b not zero",
						m_tdata[fbc_pkg::OUT_DATA_W-1:1]));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("** frustum_box_cull: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		box_t            b;
		int              mode;
		int              spread;
		fbc_pkg::coord_t cx, cy, cz;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		idle_on   = 1'b1;
		hold_req  = 1'b0;
		for (int r = 0; r < fbc_pkg::PLANE_REGS; r++)
			plane_q[r] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == RST_ROWS) begin
				drain();
				load_planes(PK_DIRECTED);
			end
			b.x_min = DIR_TBL[i].x0;
			b.x_max = DIR_TBL[i].x1;
			b.y_min = DIR_TBL[i].y0;
			b.y_max = DIR_TBL[i].y1;
			b.z_min = DIR_TBL[i].z0;
			b.z_max = DIR_TBL[i].z1;
			send_box(b, DIR_TBL[i].typed, DIR_TBL[i].outside);
		end
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			idle_on = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
			load_planes(ph == 0 ? PK_MAX : (ph == 1 ? PK_MIN : PK_RANDOM));
			if (ph == 3) begin
				// keep offering while the receiver sits out a long stall
				idle_on = 1'b1;
				@(posedge clk);
				hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				mode = $urandom_range(0, 3);
				case (mode)
					0: spread = 0;
					1: spread = $urandom_range(1, 512);
					2: spread = 2000;
					default: spread = 40;
				endcase
				cx = (mode == 1) ? fbc_pkg::coord_t'($urandom) : '0;
				cy = (mode == 1) ? fbc_pkg::coord_t'($urandom) : '0;
				cz = (mode == 1) ? fbc_pkg::coord_t'($urandom) : '0;
				b.x_min = rand_coord(spread, cx);
				b.x_max = rand_coord(spread, cx);
				b.y_min = rand_coord(spread, cy);
				b.y_max = rand_coord(spread, cy);
				b.z_min = rand_coord(spread, cz);
				b.z_max = rand_coord(spread, cz);
				send_box(b, 1'b0, 1'b0);
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (outside_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", outside_q.size()));
		if (mismatch_cnt == 0)
			$display("** frustum_box_cull: PASSED **");
		else
			$display("** frustum_box_cull: FAILED **");
		$finish;
	end

endmodule
